// ===== sv/fcg_pkg.sv =====
package fcg_pkg;

    // Field and bus geometry
    localparam int DW      = 32;
    localparam int QW      = 64;
    localparam int N_IN    = 10;
    localparam int N_OUT   = 11;
    localparam int N_CFG   = 7;
    localparam int NST     = 22;
    localparam int N_LVL   = 5;
    localparam int N_PROD  = 12;

    localparam logic signed [QW-1:0] QMAX    = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic [31:0]          QUARTER = 32'h4000_0000;
    localparam logic [29:0]          TURNK   = 30'd683565276;

    // Sine polynomial coefficients, Q30
    localparam logic signed [QW-1:0] A1 = 64'sd1686629713;
    localparam logic signed [QW-1:0] A3 = -64'sd693598668;
    localparam logic signed [QW-1:0] A5 = 64'sd85569306;
    localparam logic signed [QW-1:0] A7 = -64'sd5026989;
    localparam logic signed [QW-1:0] A9 = 64'sd172272;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_ALONG_OFFSET  = 3'd0,
        CFG_ACROSS_OFFSET = 3'd1,
        CFG_WEIGHT_ALONG  = 3'd2,
        CFG_WEIGHT_ACROSS = 3'd3,
        CFG_WEIGHT_HEAD   = 3'd4,
        CFG_WEIGHT_SPEED  = 3'd5,
        CFG_WEIGHT_TURN   = 3'd6
    } t_cfg_idx;

    // Partial products of one 63x63 magnitude multiply
    typedef struct packed {
        logic [63:0] ll;
        logic [62:0] lh;
        logic [62:0] hl;
        logic [61:0] hh;
        logic        neg;
    } t_pp;

    // Values carried down the pipeline
    typedef struct packed {
        logic [3:0][31:0] ph;
        logic [3:0][1:0]  sq;
        logic [3:0][30:0] sxv;
        logic [3:0][30:0] sx2;
        logic [3:0][63:0] st;
        logic signed [63:0] dx;
        logic signed [63:0] dy;
        logic signed [63:0] ds;
        logic signed [63:0] dt;
        logic signed [63:0] c;
        logic signed [63:0] s;
        logic signed [63:0] hs;
        logic signed [63:0] hc;
        logic signed [63:0] cdx;
        logic signed [63:0] sdy;
        logic signed [63:0] sdx;
        logic signed [63:0] cdy;
        logic signed [63:0] ar;
        logic signed [63:0] cr;
        logic signed [63:0] al;
        logic signed [63:0] ac;
        logic signed [63:0] aw;
        logic signed [63:0] gac;
        logic signed [63:0] gas;
        logic signed [63:0] xl;
        logic signed [63:0] gxs;
        logic signed [63:0] gxc;
        logic signed [63:0] xa;
        logic signed [63:0] h;
        logic signed [63:0] hg;
        logic signed [63:0] sp;
        logic signed [63:0] tn;
        logic signed [63:0] sp3;
        logic signed [63:0] tn3;
        logic signed [63:0] a4;
        logic signed [63:0] g1;
        logic signed [63:0] p1;
        logic signed [63:0] p2;
        logic signed [63:0] p3;
        logic signed [63:0] glh;
        logic signed [63:0] r0;
        logic signed [63:0] r1;
        logic signed [63:0] r2;
        logic signed [63:0] ht;
        logic signed [63:0] r4;
        logic signed [63:0] r5;
        logic signed [63:0] r6;
        logic signed [63:0] r7;
        logic signed [63:0] r8;
        logic signed [63:0] r9;
        logic signed [63:0] r10;
    } t_vals;

    // Saturating add to +-QMAX
    function automatic logic signed [63:0] qadd(input logic signed [63:0] a,
                                                input logic signed [63:0] b);
        logic signed [64:0] sum;
        sum = {a[63], a} + {b[63], b};
        if (sum > $signed({1'b0, QMAX})) return QMAX;
        if (sum < -$signed({1'b0, QMAX})) return -QMAX;
        return sum[63:0];
    endfunction

    // Multiply by 2^sh with saturation; used to multiply by 2 or 4
    function automatic logic signed [63:0] qscale(input logic signed [63:0] t,
                                                  input logic [1:0] sh);
        logic [63:0] mag;
        logic [65:0] m;
        logic [63:0] r;
        mag = t[63] ? 64'(-t) : 64'(t);
        m   = {2'b00, mag} << sh;
        r   = (m > {2'b00, QMAX}) ? QMAX : m[63:0];
        return t[63] ? -$signed(r) : $signed(r);
    endfunction

    // First half of a Q32.32 multiply: magnitudes and partial products
    function automatic t_pp qmul_pp(input logic signed [63:0] a,
                                    input logic signed [63:0] b);
        logic [63:0] ma;
        logic [63:0] mb;
        t_pp p;
        ma    = a[63] ? 64'(-a) : 64'(a);
        mb    = b[63] ? 64'(-b) : 64'(b);
        p.ll  = ma[31:0] * mb[31:0];
        p.lh  = 63'(ma[31:0] * mb[62:32]);
        p.hl  = 63'(ma[62:32] * mb[31:0]);
        p.hh  = ma[62:32] * mb[62:32];
        p.neg = a[63] ^ b[63];
        return p;
    endfunction

    // Second half: sum, truncate, saturate, sign
    function automatic logic signed [63:0] qmul_fin(input t_pp p);
        logic [127:0] f;
        logic [63:0]  r;
        f = {64'd0, p.ll} + {33'd0, p.lh, 32'd0} + {33'd0, p.hl, 32'd0}
            + {2'd0, p.hh, 64'd0};
        r = f[95:32];
        if ((|f[127:96]) || r[63]) r = QMAX;
        return p.neg ? -$signed(r) : $signed(r);
    endfunction

    // Q30 multiply, truncating toward zero; magnitudes stay within 32 bits
    function automatic logic signed [63:0] mul_q30(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic [63:0] ma;
        logic [63:0] mb;
        logic [63:0] p;
        logic [63:0] r;
        ma = a[63] ? 64'(-a) : 64'(a);
        mb = b[63] ? 64'(-b) : 64'(b);
        p  = ma[31:0] * mb[31:0];
        r  = p >> 30;
        return (a[63] ^ b[63]) ? -$signed(r) : $signed(r);
    endfunction

endpackage

// ===== sv/formation_cost_gradient_unit.sv =====
// Formation cost and gradient unit.
// Input stream (s_axis_*): one transaction carries the follower and leader pose
// and inputs, ten signed Q16.16 words. Output stream (m_axis_*): one transaction
// per input with the cost increment and ten partial derivatives, signed
// Q32.32, each saturated to +-(2^63-1).
// Configuration channel (i_cfg_*): register index and 32-bit data. The user must
// write offsets and weights only while no transaction is in flight; the block
// does not enforce this. Index 7 is ignored. Throughput: one transaction per
// cycle while the output is not stalled. The pipeline is 22 register stages:
// a phase multiply, six sine polynomial stages, five 64x64 multiply levels,
// each split into a 32x32 partial product stage and a summing stage, and
// add/saturate stages.
// Reset: all stage valid bits and the configuration registers clear; the stage
// payload registers are not reset.
// Stall: when the output holds a result the receiver does not take, the whole
// pipeline freezes and s_axis_tready drops; nothing is lost or repeated.
module formation_cost_gradient_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // fields from bit 0: follower_x, follower_y, follower_heading, follower_speed,
    // follower_turn, leader_x, leader_y, leader_heading, leader_speed, leader_turn
    input  logic [319:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // fields from bit 0: cost_term, grad_follower_x, grad_follower_y,
    // grad_follower_heading, grad_follower_speed, grad_follower_turn, grad_leader_x,
    // grad_leader_y, grad_leader_heading, grad_leader_speed, grad_leader_turn
    output logic [703:0] m_axis_tdata,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [2:0]   i_cfg_index,
    input  logic [31:0]  i_cfg_data
);

    logic [fcg_pkg::N_CFG-1:0][31:0] r_cfg;
    logic [fcg_pkg::NST-1:0]         r_vld;
    fcg_pkg::t_vals                  r_st [fcg_pkg::NST];
    fcg_pkg::t_vals                  n_st [fcg_pkg::NST];
    fcg_pkg::t_pp                    r_pp [fcg_pkg::N_LVL][fcg_pkg::N_PROD];
    fcg_pkg::t_pp                    n_pp [fcg_pkg::N_LVL][fcg_pkg::N_PROD];
    logic                            en;

    logic signed [63:0] aoff, xoff, wa, wx, wh, ws, wt;
    logic signed [31:0] fx, fy, fh, fs, ft, lx, ly, lh, ls, lt;

    // Advance unless a finished result is held back
    assign en            = !r_vld[fcg_pkg::NST-1] || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = r_vld[fcg_pkg::NST-1];
    assign o_cfg_ready   = 1'b1;

    assign fx = s_axis_tdata[31:0];
    assign fy = s_axis_tdata[63:32];
    assign fh = s_axis_tdata[95:64];
    assign fs = s_axis_tdata[127:96];
    assign ft = s_axis_tdata[159:128];
    assign lx = s_axis_tdata[191:160];
    assign ly = s_axis_tdata[223:192];
    assign lh = s_axis_tdata[255:224];
    assign ls = s_axis_tdata[287:256];
    assign lt = s_axis_tdata[319:288];

    // Registers widened to Q32.32
    assign aoff = {{16{r_cfg[fcg_pkg::CFG_ALONG_OFFSET][31]}},
                   r_cfg[fcg_pkg::CFG_ALONG_OFFSET], 16'd0};
    assign xoff = {{16{r_cfg[fcg_pkg::CFG_ACROSS_OFFSET][31]}},
                   r_cfg[fcg_pkg::CFG_ACROSS_OFFSET], 16'd0};
    assign wa   = {16'd0, r_cfg[fcg_pkg::CFG_WEIGHT_ALONG], 16'd0};
    assign wx   = {16'd0, r_cfg[fcg_pkg::CFG_WEIGHT_ACROSS], 16'd0};
    assign wh   = {16'd0, r_cfg[fcg_pkg::CFG_WEIGHT_HEAD], 16'd0};
    assign ws   = {16'd0, r_cfg[fcg_pkg::CFG_WEIGHT_SPEED], 16'd0};
    assign wt   = {16'd0, r_cfg[fcg_pkg::CFG_WEIGHT_TURN], 16'd0};

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                fcg_pkg::CFG_ALONG_OFFSET:
                    r_cfg[fcg_pkg::CFG_ALONG_OFFSET] <= i_cfg_data;
                fcg_pkg::CFG_ACROSS_OFFSET:
                    r_cfg[fcg_pkg::CFG_ACROSS_OFFSET] <= i_cfg_data;
                fcg_pkg::CFG_WEIGHT_ALONG:
                    r_cfg[fcg_pkg::CFG_WEIGHT_ALONG] <= i_cfg_data;
                fcg_pkg::CFG_WEIGHT_ACROSS:
                    r_cfg[fcg_pkg::CFG_WEIGHT_ACROSS] <= i_cfg_data;
                fcg_pkg::CFG_WEIGHT_HEAD:
                    r_cfg[fcg_pkg::CFG_WEIGHT_HEAD] <= i_cfg_data;
                fcg_pkg::CFG_WEIGHT_SPEED:
                    r_cfg[fcg_pkg::CFG_WEIGHT_SPEED] <= i_cfg_data;
                fcg_pkg::CFG_WEIGHT_TURN:
                    r_cfg[fcg_pkg::CFG_WEIGHT_TURN] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Stage logic
    always_comb begin
        logic [32:0] d33;
        logic [32:0] dh33;
        logic [47:0] pm;
        logic [48:0] phm;
        logic [31:0] pl;
        logic [31:0] phh;
        logic [30:0] xv;
        logic [61:0] xx;
        logic signed [63:0] v;

        for (int k = 1; k < fcg_pkg::NST; k++) n_st[k] = r_st[k-1];
        for (int l = 0; l < fcg_pkg::N_LVL; l++) begin
            for (int j = 0; j < fcg_pkg::N_PROD; j++) n_pp[l][j] = '0;
        end

        // Stage 0: differences and phases
        n_st[0] = '0;
        d33 = {fx[31], fx} - {lx[31], lx};
        n_st[0].dx = {{15{d33[32]}}, d33, 16'd0};
        d33 = {fy[31], fy} - {ly[31], ly};
        n_st[0].dy = {{15{d33[32]}}, d33, 16'd0};
        d33 = {fs[31], fs} - {ls[31], ls};
        n_st[0].ds = {{15{d33[32]}}, d33, 16'd0};
        d33 = {ft[31], ft} - {lt[31], lt};
        n_st[0].dt = {{15{d33[32]}}, d33, 16'd0};
        pm   = {{16{lh[31]}}, lh} * {18'd0, fcg_pkg::TURNK};
        pl   = pm[47:16];
        dh33 = {fh[31], fh} - {lh[31], lh};
        phm  = {{16{dh33[32]}}, dh33} * {19'd0, fcg_pkg::TURNK};
        phh  = phm[48:17];
        n_st[0].ph[0] = pl + fcg_pkg::QUARTER;
        n_st[0].ph[1] = pl;
        n_st[0].ph[2] = phh;
        n_st[0].ph[3] = phh + fcg_pkg::QUARTER;

        // Stage 1: quadrant, mirrored angle and its square
        for (int j = 0; j < 4; j++) begin
            n_st[1].sq[j] = r_st[0].ph[j][31:30];
            xv = {1'b0, r_st[0].ph[j][29:0]};
            if (r_st[0].ph[j][30]) xv = 31'h4000_0000 - xv;
            xx = {31'd0, xv} * {31'd0, xv};
            n_st[1].sxv[j] = xv;
            n_st[1].sx2[j] = xx[60:30];
            n_st[1].st[j]  = fcg_pkg::A9;
        end

        // Stages 2 to 5: Horner steps
        for (int j = 0; j < 4; j++) begin
            n_st[2].st[j] = fcg_pkg::A7 + fcg_pkg::mul_q30(r_st[1].st[j],
                                                           {33'd0, r_st[1].sx2[j]});
            n_st[3].st[j] = fcg_pkg::A5 + fcg_pkg::mul_q30(r_st[2].st[j],
                                                           {33'd0, r_st[2].sx2[j]});
            n_st[4].st[j] = fcg_pkg::A3 + fcg_pkg::mul_q30(r_st[3].st[j],
                                                           {33'd0, r_st[3].sx2[j]});
            n_st[5].st[j] = fcg_pkg::A1 + fcg_pkg::mul_q30(r_st[4].st[j],
                                                           {33'd0, r_st[4].sx2[j]});
        end

        // Stage 6: final multiply, clamp, sign, scale to Q32
        for (int j = 0; j < 4; j++) begin
            v = fcg_pkg::mul_q30(r_st[5].st[j], {33'd0, r_st[5].sxv[j]});
            if (v < 0) v = '0;
            if (v > 64'sh4000_0000) v = 64'sh4000_0000;
            if (r_st[5].sq[j][1]) v = -v;
            v = v <<< 2;
            case (j)
                0: n_st[6].c  = v;
                1: n_st[6].s  = v;
                2: n_st[6].hs = v;
                default: n_st[6].hc = v;
            endcase
        end

        // Level 0: rotation products and first weight products
        n_pp[0][0]  = fcg_pkg::qmul_pp(r_st[6].c, r_st[6].dx);
        n_pp[0][1]  = fcg_pkg::qmul_pp(r_st[6].s, r_st[6].dy);
        n_pp[0][2]  = fcg_pkg::qmul_pp(r_st[6].s, r_st[6].dx);
        n_pp[0][3]  = fcg_pkg::qmul_pp(r_st[6].c, r_st[6].dy);
        n_pp[0][4]  = fcg_pkg::qmul_pp(ws, r_st[6].ds);
        n_pp[0][5]  = fcg_pkg::qmul_pp(wt, r_st[6].dt);
        n_pp[0][6]  = fcg_pkg::qmul_pp(wh, r_st[6].hs);
        n_pp[0][7]  = fcg_pkg::qmul_pp(wh, r_st[6].hc);
        n_pp[0][8]  = fcg_pkg::qmul_pp(wa, r_st[6].c);
        n_pp[0][9]  = fcg_pkg::qmul_pp(wa, r_st[6].s);
        n_pp[0][10] = fcg_pkg::qmul_pp(wx, r_st[6].s);
        n_pp[0][11] = fcg_pkg::qmul_pp(wx, r_st[6].c);
        n_st[8].cdx = fcg_pkg::qmul_fin(r_pp[0][0]);
        n_st[8].sdy = fcg_pkg::qmul_fin(r_pp[0][1]);
        n_st[8].sdx = fcg_pkg::qmul_fin(r_pp[0][2]);
        n_st[8].cdy = fcg_pkg::qmul_fin(r_pp[0][3]);
        n_st[8].sp  = fcg_pkg::qmul_fin(r_pp[0][4]);
        n_st[8].tn  = fcg_pkg::qmul_fin(r_pp[0][5]);
        n_st[8].h   = fcg_pkg::qmul_fin(r_pp[0][6]);
        n_st[8].hg  = fcg_pkg::qmul_fin(r_pp[0][7]);
        n_st[8].gac = fcg_pkg::qmul_fin(r_pp[0][8]);
        n_st[8].gas = fcg_pkg::qmul_fin(r_pp[0][9]);
        n_st[8].gxs = fcg_pkg::qmul_fin(r_pp[0][10]);
        n_st[8].gxc = fcg_pkg::qmul_fin(r_pp[0][11]);

        // Rotate into the leader frame, then remove offsets
        n_st[9].ar  = fcg_pkg::qadd(r_st[8].cdx, r_st[8].sdy);
        n_st[9].cr  = fcg_pkg::qadd(-r_st[8].sdx, r_st[8].cdy);
        n_st[10].al = fcg_pkg::qadd(r_st[9].ar, -aoff);
        n_st[10].ac = fcg_pkg::qadd(r_st[9].cr, -xoff);

        // Level 1
        n_pp[1][0] = fcg_pkg::qmul_pp(wa, r_st[10].al);
        n_pp[1][1] = fcg_pkg::qmul_pp(r_st[10].gac, r_st[10].al);
        n_pp[1][2] = fcg_pkg::qmul_pp(r_st[10].gas, r_st[10].al);
        n_pp[1][3] = fcg_pkg::qmul_pp(wx, r_st[10].ac);
        n_pp[1][4] = fcg_pkg::qmul_pp(r_st[10].gxs, r_st[10].ac);
        n_pp[1][5] = fcg_pkg::qmul_pp(r_st[10].gxc, r_st[10].ac);
        n_pp[1][6] = fcg_pkg::qmul_pp(r_st[10].h, r_st[10].hs);
        n_pp[1][7] = fcg_pkg::qmul_pp(r_st[10].hg, r_st[10].hs);
        n_pp[1][8] = fcg_pkg::qmul_pp(r_st[10].sp, r_st[10].ds);
        n_pp[1][9] = fcg_pkg::qmul_pp(r_st[10].tn, r_st[10].dt);
        n_st[12].aw  = fcg_pkg::qmul_fin(r_pp[1][0]);
        n_st[12].gac = fcg_pkg::qmul_fin(r_pp[1][1]);
        n_st[12].gas = fcg_pkg::qmul_fin(r_pp[1][2]);
        n_st[12].xl  = fcg_pkg::qmul_fin(r_pp[1][3]);
        n_st[12].gxs = fcg_pkg::qmul_fin(r_pp[1][4]);
        n_st[12].gxc = fcg_pkg::qmul_fin(r_pp[1][5]);
        n_st[12].h   = fcg_pkg::qmul_fin(r_pp[1][6]);
        n_st[12].hg  = fcg_pkg::qmul_fin(r_pp[1][7]);
        n_st[12].sp  = fcg_pkg::qmul_fin(r_pp[1][8]);
        n_st[12].tn  = fcg_pkg::qmul_fin(r_pp[1][9]);

        // Level 2
        n_pp[2][0] = fcg_pkg::qmul_pp(r_st[12].aw, r_st[12].al);
        n_pp[2][1] = fcg_pkg::qmul_pp(r_st[12].gac, r_st[12].al);
        n_pp[2][2] = fcg_pkg::qmul_pp(r_st[12].gas, r_st[12].al);
        n_pp[2][3] = fcg_pkg::qmul_pp(r_st[12].xl, r_st[12].ac);
        n_pp[2][4] = fcg_pkg::qmul_pp(r_st[12].xl, r_st[12].ar);
        n_pp[2][5] = fcg_pkg::qmul_pp(r_st[12].h, r_st[12].hs);
        n_pp[2][6] = fcg_pkg::qmul_pp(r_st[12].hg, r_st[12].hs);
        n_pp[2][7] = fcg_pkg::qmul_pp(r_st[12].sp, r_st[12].ds);
        n_pp[2][8] = fcg_pkg::qmul_pp(r_st[12].tn, r_st[12].dt);
        n_st[14].aw  = fcg_pkg::qmul_fin(r_pp[2][0]);
        n_st[14].gac = fcg_pkg::qmul_fin(r_pp[2][1]);
        n_st[14].gas = fcg_pkg::qmul_fin(r_pp[2][2]);
        n_st[14].xl  = fcg_pkg::qmul_fin(r_pp[2][3]);
        n_st[14].xa  = fcg_pkg::qmul_fin(r_pp[2][4]);
        n_st[14].h   = fcg_pkg::qmul_fin(r_pp[2][5]);
        n_st[14].hg  = fcg_pkg::qmul_fin(r_pp[2][6]);
        n_st[14].sp  = fcg_pkg::qmul_fin(r_pp[2][7]);
        n_st[14].tn  = fcg_pkg::qmul_fin(r_pp[2][8]);

        // Level 3: keep the cubed speed and turn terms for the gradient
        n_pp[3][0] = fcg_pkg::qmul_pp(r_st[14].aw, r_st[14].al);
        n_pp[3][1] = fcg_pkg::qmul_pp(r_st[14].gac, r_st[14].al);
        n_pp[3][2] = fcg_pkg::qmul_pp(r_st[14].gas, r_st[14].al);
        n_pp[3][3] = fcg_pkg::qmul_pp(r_st[14].h, r_st[14].hs);
        n_pp[3][4] = fcg_pkg::qmul_pp(r_st[14].hg, r_st[14].hs);
        n_pp[3][5] = fcg_pkg::qmul_pp(r_st[14].sp, r_st[14].ds);
        n_pp[3][6] = fcg_pkg::qmul_pp(r_st[14].tn, r_st[14].dt);
        n_st[16].aw  = fcg_pkg::qmul_fin(r_pp[3][0]);
        n_st[16].gac = fcg_pkg::qmul_fin(r_pp[3][1]);
        n_st[16].gas = fcg_pkg::qmul_fin(r_pp[3][2]);
        n_st[16].h   = fcg_pkg::qmul_fin(r_pp[3][3]);
        n_st[16].hg  = fcg_pkg::qmul_fin(r_pp[3][4]);
        n_st[16].sp  = fcg_pkg::qmul_fin(r_pp[3][5]);
        n_st[16].tn  = fcg_pkg::qmul_fin(r_pp[3][6]);
        n_st[16].sp3 = r_st[15].sp;
        n_st[16].tn3 = r_st[15].tn;

        // Level 4: fourth power of along error and its heading cross term
        n_pp[4][0] = fcg_pkg::qmul_pp(r_st[16].aw, r_st[16].al);
        n_pp[4][1] = fcg_pkg::qmul_pp(r_st[16].aw, r_st[16].cr);
        n_st[18].a4 = fcg_pkg::qmul_fin(r_pp[4][0]);
        n_st[18].g1 = fcg_pkg::qmul_fin(r_pp[4][1]);

        // Scale by the integer factors and combine
        n_st[19].p1  = fcg_pkg::qadd(r_st[18].a4, r_st[18].xl);
        n_st[19].p2  = fcg_pkg::qadd(r_st[18].h, r_st[18].sp);
        n_st[19].r1  = fcg_pkg::qadd(fcg_pkg::qscale(r_st[18].gac, 2'd2),
                                     -fcg_pkg::qscale(r_st[18].gxs, 2'd1));
        n_st[19].r2  = fcg_pkg::qadd(fcg_pkg::qscale(r_st[18].gas, 2'd2),
                                     fcg_pkg::qscale(r_st[18].gxc, 2'd1));
        n_st[19].ht  = fcg_pkg::qscale(r_st[18].hg, 2'd1);
        n_st[19].r4  = fcg_pkg::qscale(r_st[18].sp3, 2'd2);
        n_st[19].r5  = fcg_pkg::qscale(r_st[18].tn3, 2'd2);
        n_st[19].glh = fcg_pkg::qadd(fcg_pkg::qscale(r_st[18].g1, 2'd2),
                                     -fcg_pkg::qscale(r_st[18].xa, 2'd1));

        n_st[20].p3  = fcg_pkg::qadd(r_st[19].p1, r_st[19].p2);
        n_st[20].r8  = fcg_pkg::qadd(r_st[19].glh, -r_st[19].ht);
        n_st[20].r6  = -r_st[19].r1;
        n_st[20].r7  = -r_st[19].r2;
        n_st[20].r9  = -r_st[19].r4;
        n_st[20].r10 = -r_st[19].r5;

        n_st[21].r0 = fcg_pkg::qadd(r_st[20].p3, r_st[20].tn);
    end

    // Stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[fcg_pkg::NST-2:0], s_axis_tvalid};
        end
    end

    // Stage payload, held while stalled
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < fcg_pkg::NST; k++) r_st[k] <= n_st[k];
            r_pp[0] <= n_pp[0];
            r_pp[1] <= n_pp[1];
            r_pp[2] <= n_pp[2];
            r_pp[3] <= n_pp[3];
            r_pp[4] <= n_pp[4];
        end
    end

    assign m_axis_tdata = {r_st[fcg_pkg::NST-1].r10, r_st[fcg_pkg::NST-1].r9,
                           r_st[fcg_pkg::NST-1].r8,  r_st[fcg_pkg::NST-1].r7,
                           r_st[fcg_pkg::NST-1].r6,  r_st[fcg_pkg::NST-1].r5,
                           r_st[fcg_pkg::NST-1].r4,  r_st[fcg_pkg::NST-1].ht,
                           r_st[fcg_pkg::NST-1].r2,  r_st[fcg_pkg::NST-1].r1,
                           r_st[fcg_pkg::NST-1].r0};

    // A held result blocks new input
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
        else $error("input taken while output stalled");

    // Leader position gradients mirror the follower ones
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ($signed(m_axis_tdata[447:384]) == -$signed(m_axis_tdata[127:64]))
                       && ($signed(m_axis_tdata[511:448]) == -$signed(m_axis_tdata[191:128])))
        else $error("leader gradient not mirrored");

    // No result directly after reset
    assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

endmodule

// ===== dv/tb_formation_cost_gradient_unit.sv =====
module tb_formation_cost_gradient_unit;

    localparam logic [2:0]         CFG_UNUSED = 3'd7;
    localparam logic signed [63:0] ONE_Q32    = 64'sh1_0000_0000;
    localparam int                 PIPE_LAT   = 22;
    localparam int                 LONG_STALL = 120;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [319:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [703:0] m_axis_tdata;
    logic         i_cfg_valid = 1'b0;
    logic         o_cfg_ready;
    logic [2:0]   i_cfg_index = '0;
    logic [31:0]  i_cfg_data = '0;

    logic [319:0] pending_q[$];
    logic [703:0] grad_expect_q[$];
    logic [31:0]  cfg_shadow[fcg_pkg::N_CFG];
    int           err_cnt = 0;
    bit           stall_trig = 1'b0;

    formation_cost_gradient_unit dut (.*);

    always #1 i_clk = ~i_clk;

    // Saturating Q32.32 arithmetic, truncating toward zero
    function automatic logic signed [63:0] sat_add(logic signed [63:0] a, logic signed [63:0] b);
        logic signed [64:0] sum;
        sum = 65'(a) + 65'(b);
        if (sum > 65'(fcg_pkg::QMAX)) return fcg_pkg::QMAX;
        if (sum < -65'(fcg_pkg::QMAX)) return -fcg_pkg::QMAX;
        return sum[63:0];
    endfunction

    function automatic logic signed [63:0] sat_mul(logic signed [63:0] a, logic signed [63:0] b);
        logic [127:0] ma;
        logic [127:0] mb;
        logic [127:0] prod;
        logic [63:0]  r;
        ma   = a[63] ? 128'(-65'(a)) : 128'(a);
        mb   = b[63] ? 128'(-65'(b)) : 128'(b);
        prod = (ma * mb) >> 32;
        r    = (prod > 128'(fcg_pkg::QMAX)) ? fcg_pkg::QMAX : prod[63:0];
        return (a[63] != b[63]) ? -$signed(r) : $signed(r);
    endfunction

    function automatic logic signed [63:0] q30_mul(logic signed [63:0] a, logic signed [63:0] b);
        logic [63:0] r;
        r = ((a[63] ? -a : a) * (b[63] ? -b : b)) >> 30;
        return (a[63] != b[63]) ? -$signed(r) : $signed(r);
    endfunction

    // Polynomial sine of a 32-bit phase, result Q32.32
    function automatic logic signed [63:0] phase_sine(logic [31:0] p);
        logic signed [63:0] x;
        logic signed [63:0] x2;
        logic signed [63:0] t;
        x = {34'd0, p[29:0]};
        if (p[30]) x = 64'sh4000_0000 - x;
        x2 = q30_mul(x, x);
        t  = fcg_pkg::A9;
        t  = fcg_pkg::A7 + q30_mul(t, x2);
        t  = fcg_pkg::A5 + q30_mul(t, x2);
        t  = fcg_pkg::A3 + q30_mul(t, x2);
        t  = fcg_pkg::A1 + q30_mul(t, x2);
        t  = q30_mul(t, x);
        if (t < 0) t = 0;
        if (t > 64'sh4000_0000) t = 64'sh4000_0000;
        if (p[31]) t = -t;
        return t <<< 2;
    endfunction

    function automatic logic [31:0] angle_phase(logic signed [63:0] a, int sh);
        logic [63:0] p;
        p = $unsigned(a) * 64'd683565276;
        return p[sh +: 32];
    endfunction

    function automatic logic signed [63:0] weighted_pow(logic signed [63:0] w,
            logic signed [63:0] f, logic signed [63:0] x, int n);
        logic signed [63:0] t;
        t = sat_mul(w, f);
        for (int i = 0; i < n; i++) t = sat_mul(t, x);
        return t;
    endfunction

    function automatic string field_name(int k);
        case (k)
            0: return "cost_term";
            1: return "grad_follower_x";
            2: return "grad_follower_y";
            3: return "grad_follower_heading";
            4: return "grad_follower_speed";
            5: return "grad_follower_turn";
            6: return "grad_leader_x";
            7: return "grad_leader_y";
            8: return "grad_leader_heading";
            9: return "grad_leader_speed";
            default: return "grad_leader_turn";
        endcase
    endfunction

    // Cost and gradient of one pose pair under the current register copy
    function automatic logic [703:0] formation_grad(logic [319:0] d);
        logic signed [63:0] f[10];
        logic signed [63:0] r[11];
        logic signed [63:0] aoff, xoff, wa, wx, wh, ws, wt, two, four;
        logic signed [63:0] c, s, hs, hc, dx, dy, ds, dt, ar, cr, al, ac, ht, glh;
        logic [31:0] pl, ph;
        logic [703:0] out;
        for (int k = 0; k < 10; k++) f[k] = 64'($signed(d[32*k +: 32]));
        aoff = 64'($signed(cfg_shadow[fcg_pkg::CFG_ALONG_OFFSET])) <<< 16;
        xoff = 64'($signed(cfg_shadow[fcg_pkg::CFG_ACROSS_OFFSET])) <<< 16;
        wa   = 64'(cfg_shadow[fcg_pkg::CFG_WEIGHT_ALONG]) <<< 16;
        wx   = 64'(cfg_shadow[fcg_pkg::CFG_WEIGHT_ACROSS]) <<< 16;
        wh   = 64'(cfg_shadow[fcg_pkg::CFG_WEIGHT_HEAD]) <<< 16;
        ws   = 64'(cfg_shadow[fcg_pkg::CFG_WEIGHT_SPEED]) <<< 16;
        wt   = 64'(cfg_shadow[fcg_pkg::CFG_WEIGHT_TURN]) <<< 16;
        two  = 2 * ONE_Q32;
        four = 4 * ONE_Q32;
        pl   = angle_phase(f[7], 16);
        ph   = angle_phase(f[2] - f[7], 17);
        c    = phase_sine(pl + fcg_pkg::QUARTER);
        s    = phase_sine(pl);
        hs   = phase_sine(ph);
        hc   = phase_sine(ph + fcg_pkg::QUARTER);
        dx   = (f[0] - f[5]) <<< 16;
        dy   = (f[1] - f[6]) <<< 16;
        ds   = (f[3] - f[8]) <<< 16;
        dt   = (f[4] - f[9]) <<< 16;
        ar   = sat_add(sat_mul(c, dx), sat_mul(s, dy));
        cr   = sat_add(-sat_mul(s, dx), sat_mul(c, dy));
        al   = sat_add(ar, -aoff);
        ac   = sat_add(cr, -xoff);
        r[0] = sat_add(sat_add(sat_add(sat_add(weighted_pow(wa, ONE_Q32, al, 4),
               weighted_pow(wx, ONE_Q32, ac, 2)), weighted_pow(wh, ONE_Q32, hs, 4)),
               weighted_pow(ws, ONE_Q32, ds, 4)), weighted_pow(wt, ONE_Q32, dt, 4));
        r[1] = sat_add(sat_mul(weighted_pow(wa, c, al, 3), four),
                       -sat_mul(weighted_pow(wx, s, ac, 1), two));
        r[2] = sat_add(sat_mul(weighted_pow(wa, s, al, 3), four),
                       sat_mul(weighted_pow(wx, c, ac, 1), two));
        ht   = sat_mul(weighted_pow(wh, hc, hs, 3), two);
        r[3] = ht;
        r[4] = sat_mul(weighted_pow(ws, ONE_Q32, ds, 3), four);
        r[5] = sat_mul(weighted_pow(wt, ONE_Q32, dt, 3), four);
        r[6] = -r[1];
        r[7] = -r[2];
        glh  = sat_add(sat_mul(sat_mul(weighted_pow(wa, ONE_Q32, al, 3), cr), four),
                       -sat_mul(sat_mul(weighted_pow(wx, ONE_Q32, ac, 1), ar), two));
        r[8] = sat_add(glh, -ht);
        r[9] = -r[4];
        r[10] = -r[5];
        for (int k = 0; k < 11; k++) out[64*k +: 64] = r[k];
        return out;
    endfunction

    // Drive input transactions in bursts with random gaps
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready)
            grad_expect_q.push_back(formation_grad(s_axis_tdata));
        if (i_rst_n && (!s_axis_tvalid || s_axis_tready)) begin
            if (gap_left > 0 || pending_q.size() == 0) begin
                s_axis_tvalid <= 1'b0;
                if (gap_left > 0) gap_left <= gap_left - 1;
            end else begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= pending_q.pop_front();
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 30);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end
        end
    end

    // Check output transactions; stall on a random pattern plus long hold-offs
    int  stall_left = 0;
    bit  stall_seen = 1'b0;
    int  pat_mode = 0;
    logic [703:0] want;
    always @(posedge i_clk) begin
        if (m_axis_tvalid && m_axis_tready) begin
            if (grad_expect_q.size() == 0) begin
                $error("unexpected result transaction");
                err_cnt++;
            end else begin
                want = grad_expect_q.pop_front();
                for (int k = 0; k < fcg_pkg::N_OUT; k++)
                    if (want[64*k +: 64] !== m_axis_tdata[64*k +: 64]) begin
                        $error("%s exp %h act %h",
                               field_name(k), want[64*k +: 64], m_axis_tdata[64*k +: 64]);
                        err_cnt++;
                    end
            end
        end
        if (stall_trig != stall_seen) begin
            stall_seen <= stall_trig;
            stall_left <= LONG_STALL;
            m_axis_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            if ($urandom_range(0, 63) == 0) pat_mode <= $urandom_range(0, 2);
            case (pat_mode)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= ($urandom_range(0, 3) != 0);
                default: m_axis_tready <= ($urandom_range(0, 1) != 0);
            endcase
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        if (idx < fcg_pkg::N_CFG) cfg_shadow[idx] = val;
        @(posedge i_clk);
    endtask

    // Wait on settled values until nothing is queued, offered or outstanding
    task automatic drain();
        @(negedge i_clk);
        while (pending_q.size() != 0 || s_axis_tvalid || grad_expect_q.size() != 0)
            @(negedge i_clk);
        repeat (PIPE_LAT + 4) @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_field(int mode);
        case (mode)
            0: return $urandom;
            1: return $urandom_range(0, 32'h3_FFFF) - 32'h2_0000;
            default: return $urandom_range(0, 32'h1FF_FFFF) - 32'h100_0000;
        endcase
    endfunction

    task automatic random_items(int n);
        logic [319:0] v;
        int mode;
        for (int i = 0; i < n; i++) begin
            mode = $urandom_range(0, 9);
            for (int k = 0; k < 10; k++)
                v[32*k +: 32] = pick_field(mode < 2 ? 0 : (mode < 6 ? 1 : 2));
            pending_q.push_back(v);
        end
    endtask

    task automatic load_regs(logic [31:0] ao, logic [31:0] xo, logic [31:0] wa,
                             logic [31:0] wx, logic [31:0] wh, logic [31:0] ws,
                             logic [31:0] wt);
        write_reg(fcg_pkg::CFG_ALONG_OFFSET, ao);
        write_reg(fcg_pkg::CFG_ACROSS_OFFSET, xo);
        write_reg(fcg_pkg::CFG_WEIGHT_ALONG, wa);
        write_reg(fcg_pkg::CFG_WEIGHT_ACROSS, wx);
        write_reg(fcg_pkg::CFG_WEIGHT_HEAD, wh);
        write_reg(fcg_pkg::CFG_WEIGHT_SPEED, ws);
        write_reg(fcg_pkg::CFG_WEIGHT_TURN, wt);
    endtask

    initial begin
        logic [319:0] v;
        for (int k = 0; k < fcg_pkg::N_CFG; k++) cfg_shadow[k] = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset weights: every output zero
        random_items(10);
        drain();

        // Unit weights with a modest offset; directed corner poses first
        load_regs(32'hFFFE_0000, 32'h0001_8000, 32'h0001_0000, 32'h0001_0000,
                  32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
        write_reg(CFG_UNUSED, 32'hFFFF_FFFF);
        pending_q.push_back('0);
        pending_q.push_back({10{32'h7FFF_FFFF}});
        pending_q.push_back({10{32'h8000_0000}});
        pending_q.push_back({{5{32'h8000_0000}}, {5{32'h7FFF_FFFF}}});
        pending_q.push_back({{5{32'h7FFF_FFFF}}, {5{32'h8000_0000}}});
        for (int h = 0; h < 8; h++) begin
            // Leader heading swept through quadrants, follower ahead and aside
            v = '0;
            v[32*0 +: 32] = 32'h0003_0000;
            v[32*1 +: 32] = 32'hFFFF_0000;
            v[32*2 +: 32] = 32'h7FFF_FFFF - h * 32'h0F00_0000;
            v[32*3 +: 32] = 32'h0002_0000;
            v[32*4 +: 32] = 32'hFFFF_8000;
            v[32*7 +: 32] = h * 32'h0000_C90F;
            pending_q.push_back(v);
        end
        for (int k = 0; k < 10; k++) pending_q.push_back(320'(32'h0001_0000) << (32 * k));
        drain();

        // Sender keeps offering while the receiver holds off
        stall_trig = ~stall_trig;
        random_items(90);
        drain();

        // Extreme registers: largest offset magnitudes and weights
        load_regs(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        random_items(70);
        drain();

        load_regs(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'h0000_0000,
                  32'h0000_0001, 32'h0000_0000, 32'h0000_0001);
        random_items(50);
        drain();

        // Random registers, several rounds
        for (int p = 0; p < 3; p++) begin
            load_regs(pick_field(1 + p % 2), pick_field(1 + p % 2), $urandom_range(0, 32'h8_0000),
                      $urandom, $urandom_range(0, 32'h8_0000), $urandom_range(0, 32'h4_0000),
                      $urandom_range(0, 32'h4_0000));
            if (p == 1) stall_trig = ~stall_trig;
            random_items(60);
            drain();
        end

        if (err_cnt == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Count expectations left behind by a hung output as a failure via timeout
    initial begin
        #400000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== files.f =====
sv/fcg_pkg.sv
sv/formation_cost_gradient_unit.sv
dv/tb_formation_cost_gradient_unit.sv
